### sv/bbc_pkg.sv
// ----------------------------------------------------------------------------
// bbc_pkg: shared types and constants of the bracket balance checker
// Holds the command and op codes, the bracket kinds, the report status codes
// and the tables that map a bracket kind to its opener and closer ASCII code.
// ----------------------------------------------------------------------------
package bbc_pkg;

	// stack sizing
	localparam int STACK_DEPTH = 64;
	localparam int STACK_AW    = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
	localparam int LEVEL_W     = $clog2(STACK_DEPTH + 1);

	// queue between the front and back parts
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	localparam int LINE_W = 16;

	// input commands
	typedef enum logic [1:0] {
		CMD_CHAR = 2'd0,
		CMD_EOL  = 2'd1,
		CMD_EOT  = 2'd2
	} cmd_t;

	// bracket kinds as held on the stack
	typedef enum logic [1:0] {
		KIND_ROUND  = 2'd0,
		KIND_SQUARE = 2'd1,
		KIND_CURLY  = 2'd2
	} kind_t;

	// report status
	typedef enum logic [1:0] {
		ST_BALANCED = 2'd0,
		ST_MISMATCH = 2'd1,
		ST_UNCLOSED = 2'd2,
		ST_OVERFLOW = 2'd3
	} status_t;

	// classified operations handed to the back part
	typedef enum logic [1:0] {
		OP_PUSH = 2'd0,
		OP_POP  = 2'd1,
		OP_EOL  = 2'd2,
		OP_EOT  = 2'd3
	} op_code_t;

	typedef struct packed {
		op_code_t code;
		kind_t    kind;
	} op_t;

	// bracket characters
	localparam logic [7:0] CH_LROUND  = 8'h28;
	localparam logic [7:0] CH_RROUND  = 8'h29;
	localparam logic [7:0] CH_LSQUARE = 8'h5B;
	localparam logic [7:0] CH_RSQUARE = 8'h5D;
	localparam logic [7:0] CH_LCURLY  = 8'h7B;
	localparam logic [7:0] CH_RCURLY  = 8'h7D;
	localparam logic [7:0] CH_NONE    = 8'h00;

	function automatic logic [7:0] opener_ascii(input logic [1:0] k);
		logic [7:0] c;
		unique case (k)
			KIND_ROUND:  c = CH_LROUND;
			KIND_SQUARE: c = CH_LSQUARE;
			KIND_CURLY:  c = CH_LCURLY;
			default:     c = CH_NONE;
		endcase
		return c;
	endfunction

	function automatic logic [7:0] closer_ascii(input logic [1:0] k);
		logic [7:0] c;
		unique case (k)
			KIND_ROUND:  c = CH_RROUND;
			KIND_SQUARE: c = CH_RSQUARE;
			KIND_CURLY:  c = CH_RCURLY;
			default:     c = CH_NONE;
		endcase
		return c;
	endfunction

endpackage

### sv/bbc_ram.sv
// ----------------------------------------------------------------------------
// bbc_ram: generic single-write, single-read RAM
// One write port and one read port; the read data is registered.
// ----------------------------------------------------------------------------
module bbc_ram #(
	parameter int WIDTH = 2,
	parameter int DEPTH = 64
) (
	input  logic                                    clk,
	input  logic                                    wr_en,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
	input  logic [WIDTH-1:0]                        wr_data,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
	output logic [WIDTH-1:0]                        rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	// write and registered read
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data_q <= mem_q[rd_addr];
	end

	assign rd_data = rd_data_q;

endmodule

### sv/bbc_front.sv
// ----------------------------------------------------------------------------
// bbc_front: request intake and classification
// Accepts one request per cycle unless stalled, turns it into a push, pop, end
// of line or end of text op, drops all else, holds it in one stage register.
// ----------------------------------------------------------------------------
module bbc_front (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             char_valid,
	output logic             char_stall,
	input  logic [1:0]       command,
	input  logic [7:0]       char_code,
	output logic             op_valid,
	output bbc_pkg::op_t     op,
	input  logic             op_ready
);

	logic         valid_s1;
	bbc_pkg::op_t op_s1;
	logic         accept;
	logic         keep;
	bbc_pkg::op_t op_d;

	// classify the request
	always_comb begin
		keep      = 1'b0;
		op_d.code = bbc_pkg::OP_EOL;
		op_d.kind = bbc_pkg::KIND_ROUND;
		unique case (command)
			bbc_pkg::CMD_CHAR: begin
				unique case (char_code)
					bbc_pkg::CH_LROUND: begin
						keep = 1'b1; op_d.code = bbc_pkg::OP_PUSH;
						op_d.kind = bbc_pkg::KIND_ROUND;
					end
					bbc_pkg::CH_LSQUARE: begin
						keep = 1'b1; op_d.code = bbc_pkg::OP_PUSH;
						op_d.kind = bbc_pkg::KIND_SQUARE;
					end
					bbc_pkg::CH_LCURLY: begin
						keep = 1'b1; op_d.code = bbc_pkg::OP_PUSH;
						op_d.kind = bbc_pkg::KIND_CURLY;
					end
					bbc_pkg::CH_RROUND: begin
						keep = 1'b1; op_d.code = bbc_pkg::OP_POP;
						op_d.kind = bbc_pkg::KIND_ROUND;
					end
					bbc_pkg::CH_RSQUARE: begin
						keep = 1'b1; op_d.code = bbc_pkg::OP_POP;
						op_d.kind = bbc_pkg::KIND_SQUARE;
					end
					bbc_pkg::CH_RCURLY: begin
						keep = 1'b1; op_d.code = bbc_pkg::OP_POP;
						op_d.kind = bbc_pkg::KIND_CURLY;
					end
					default: keep = 1'b0;
				endcase
			end
			bbc_pkg::CMD_EOL: begin
				keep = 1'b1; op_d.code = bbc_pkg::OP_EOL;
			end
			bbc_pkg::CMD_EOT: begin
				keep = 1'b1; op_d.code = bbc_pkg::OP_EOT;
			end
			default: keep = 1'b0;
		endcase
	end

	// hold the request while the queue is full
	assign char_stall = valid_s1 && !op_ready;
	assign accept     = char_valid && !char_stall;

	// advance the stage register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= keep;
		end else if (op_ready) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1 <= op_d;
		end
	end

	assign op_valid = valid_s1;
	assign op       = op_s1;

endmodule

### sv/bbc_queue.sv
// ----------------------------------------------------------------------------
// bbc_queue: short op queue between the front and back parts
// A small register FIFO; ready drops only when every slot is taken.
// ----------------------------------------------------------------------------
module bbc_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push_valid,
	input  bbc_pkg::op_t        push_op,
	output logic                push_ready,
	output logic                pop_valid,
	output bbc_pkg::op_t        pop_op,
	input  logic                pop
);

	bbc_pkg::op_t                   slot_q [bbc_pkg::QUEUE_DEPTH];
	logic [bbc_pkg::QPTR_W-1:0]     wr_ptr_q;
	logic [bbc_pkg::QPTR_W-1:0]     rd_ptr_q;
	logic [bbc_pkg::QCNT_W-1:0]     count_q;
	logic                           do_push;
	logic                           do_pop;

	assign push_ready = (count_q != bbc_pkg::QCNT_W'(bbc_pkg::QUEUE_DEPTH));
	assign pop_valid  = (count_q != '0);
	assign pop_op     = slot_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop && pop_valid;

	// advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == bbc_pkg::QPTR_W'(bbc_pkg::QUEUE_DEPTH - 1))
					? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == bbc_pkg::QPTR_W'(bbc_pkg::QUEUE_DEPTH - 1))
					? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// store the pushed op
	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= push_op;
		end
	end

endmodule

### sv/bbc_back.sv
// ----------------------------------------------------------------------------
// bbc_back: stack execution and report register
// Runs one op per cycle on the stack; an end of text loads the report, waiting
// if the report slot is busy. The top two entries live in registers; the RAM
// read is aimed one entry lower so back-to-back pops always find their data.
// ----------------------------------------------------------------------------
module bbc_back (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        op_valid,
	input  bbc_pkg::op_t                op,
	output logic                        op_pop,
	output logic                        report_valid,
	input  logic                        report_stall,
	output logic [1:0]                  status,
	output logic [bbc_pkg::LINE_W-1:0]  fault_line,
	output logic [7:0]                  bracket_char
);

	logic [bbc_pkg::LEVEL_W-1:0]   level_q, level_d;
	bbc_pkg::kind_t                top_q, top_d;
	bbc_pkg::kind_t                below_q, below_d;
	logic [bbc_pkg::LINE_W-1:0]    line_q, line_d;
	bbc_pkg::status_t              err_q, err_d;
	logic [bbc_pkg::LINE_W-1:0]    err_line_q, err_line_d;
	bbc_pkg::kind_t                err_kind_q, err_kind_d;

	logic                          report_valid_q;
	logic [1:0]                    status_q;
	logic [bbc_pkg::LINE_W-1:0]    fault_line_q;
	logic [7:0]                    bracket_char_q;

	logic                          out_free;
	logic                          exec;
	logic                          emit;
	logic [bbc_pkg::LINE_W-1:0]    cur_line;
	logic [bbc_pkg::LEVEL_W-1:0]   rd_level;
	logic                          wr_en;
	logic [bbc_pkg::STACK_AW-1:0]  wr_addr;
	logic [bbc_pkg::STACK_AW-1:0]  rd_addr;
	logic [1:0]                    rd_data;
	bbc_pkg::status_t              rep_status;
	logic [bbc_pkg::LINE_W-1:0]    rep_line;
	logic [7:0]                    rep_char;

	// take an op unless it is an end of text with the report slot busy
	assign out_free = !report_valid_q || !report_stall;
	assign exec     = op_valid && ((op.code != bbc_pkg::OP_EOT) || out_free);
	assign op_pop   = exec;
	assign emit     = exec && (op.code == bbc_pkg::OP_EOT);

	assign cur_line = (line_q == '1) ? line_q : line_q + 1'b1;

	// execute the op
	always_comb begin
		level_d    = level_q;
		top_d      = top_q;
		below_d    = below_q;
		line_d     = line_q;
		err_d      = err_q;
		err_line_d = err_line_q;
		err_kind_d = err_kind_q;
		wr_en      = 1'b0;
		wr_addr    = level_q[bbc_pkg::STACK_AW-1:0];
		if (exec) begin
			unique case (op.code)
				bbc_pkg::OP_PUSH: begin
					if (err_q == bbc_pkg::ST_BALANCED) begin
						if (level_q == bbc_pkg::LEVEL_W'(bbc_pkg::STACK_DEPTH)) begin
							err_d      = bbc_pkg::ST_OVERFLOW;
							err_line_d = cur_line;
							err_kind_d = bbc_pkg::KIND_ROUND;
						end else begin
							wr_en   = 1'b1;
							below_d = top_q;
							top_d   = op.kind;
							level_d = level_q + 1'b1;
						end
					end
				end
				bbc_pkg::OP_POP: begin
					if (err_q == bbc_pkg::ST_BALANCED) begin
						if ((level_q != '0) && (top_q == op.kind)) begin
							top_d   = below_q;
							below_d = bbc_pkg::kind_t'(rd_data);
							level_d = level_q - 1'b1;
						end else begin
							err_d      = bbc_pkg::ST_MISMATCH;
							err_line_d = cur_line;
							err_kind_d = op.kind;
						end
					end
				end
				bbc_pkg::OP_EOL: begin
					line_d = cur_line;
				end
				bbc_pkg::OP_EOT: begin
					level_d    = '0;
					line_d     = '0;
					err_d      = bbc_pkg::ST_BALANCED;
					err_line_d = '0;
					err_kind_d = bbc_pkg::KIND_ROUND;
				end
				default: level_d = level_q;
			endcase
		end
	end

	// aim the read at the entry under the next-state second entry
	assign rd_level = level_d - bbc_pkg::LEVEL_W'(3);
	assign rd_addr  = rd_level[bbc_pkg::STACK_AW-1:0];

	bbc_ram #(
		.WIDTH(2),
		.DEPTH(bbc_pkg::STACK_DEPTH)
	) u_stack (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (op.kind),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	// build the report from the latched state
	always_comb begin
		rep_status = bbc_pkg::ST_BALANCED;
		rep_line   = '0;
		rep_char   = bbc_pkg::CH_NONE;
		priority if (err_q == bbc_pkg::ST_MISMATCH) begin
			rep_status = bbc_pkg::ST_MISMATCH;
			rep_line   = err_line_q;
			rep_char   = bbc_pkg::opener_ascii(err_kind_q);
		end else if (err_q == bbc_pkg::ST_OVERFLOW) begin
			rep_status = bbc_pkg::ST_OVERFLOW;
			rep_line   = err_line_q;
		end else if (level_q != '0) begin
			rep_status = bbc_pkg::ST_UNCLOSED;
			rep_line   = line_q;
			rep_char   = bbc_pkg::closer_ascii(top_q);
		end else begin
			rep_status = bbc_pkg::ST_BALANCED;
		end
	end

	// update control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level_q        <= '0;
			line_q         <= '0;
			err_q          <= bbc_pkg::ST_BALANCED;
			err_line_q     <= '0;
			err_kind_q     <= bbc_pkg::KIND_ROUND;
			report_valid_q <= 1'b0;
		end else begin
			level_q    <= level_d;
			line_q     <= line_d;
			err_q      <= err_d;
			err_line_q <= err_line_d;
			err_kind_q <= err_kind_d;
			if (emit) begin
				report_valid_q <= 1'b1;
			end else if (!report_stall) begin
				report_valid_q <= 1'b0;
			end
		end
	end

	// hold stack top registers and report payload
	always_ff @(posedge clk) begin
		top_q   <= top_d;
		below_q <= below_d;
		if (emit) begin
			status_q       <= rep_status;
			fault_line_q   <= rep_line;
			bracket_char_q <= rep_char;
		end
	end

	assign report_valid = report_valid_q;
	assign status       = status_q;
	assign fault_line   = fault_line_q;
	assign bracket_char = bracket_char_q;

endmodule

### sv/bracket_balance_checker.sv
// Report path: an end-of-text request passes the front stage register, the op
//   queue and the report register; other requests never produce a report.
// Throughput: one request per cycle unless stalled, set by one push or pop per
//   cycle in the back part with the top two stack entries held in registers.
// Reset: asynchronous, clears level, line count, error latch and all valids;
//   the stack RAM is not cleared, only entries written since are read.
// ----------------------------------------------------------------------------
// bracket_balance_checker: balanced bracket checker top level
// Front part classifies requests, a two-entry queue decouples it from the
// back part, which runs the bracket stack and issues the end-of-text report.
// ----------------------------------------------------------------------------
module bracket_balance_checker (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        char_valid,
	output logic                        char_stall,
	input  logic [1:0]                  command,
	input  logic [7:0]                  char_code,
	output logic                        report_valid,
	input  logic                        report_stall,
	output logic [1:0]                  status,
	output logic [bbc_pkg::LINE_W-1:0]  fault_line,
	output logic [7:0]                  bracket_char
);

	logic         f_valid;
	bbc_pkg::op_t f_op;
	logic         f_ready;
	logic         q_valid;
	bbc_pkg::op_t q_op;
	logic         q_pop;

	bbc_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.char_valid (char_valid),
		.char_stall (char_stall),
		.command    (command),
		.char_code  (char_code),
		.op_valid   (f_valid),
		.op         (f_op),
		.op_ready   (f_ready)
	);

	bbc_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (f_valid),
		.push_op    (f_op),
		.push_ready (f_ready),
		.pop_valid  (q_valid),
		.pop_op     (q_op),
		.pop        (q_pop)
	);

	bbc_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.op_valid     (q_valid),
		.op           (q_op),
		.op_pop       (q_pop),
		.report_valid (report_valid),
		.report_stall (report_stall),
		.status       (status),
		.fault_line   (fault_line),
		.bracket_char (bracket_char)
	);

endmodule

### sim/tb_bracket_balance_checker.sv
// ----------------------------------------------------------------------------
// tb_bracket_balance_checker: self-checking bench for the bracket checker
// Drives character, end-of-line and end-of-text requests and predicts each
// end-of-text report with a bracket-nesting scoreboard. Reports are compared
// field by field in order. Random idling runs on both sides, with one long
// report hold-off that backs up the request side.
// ----------------------------------------------------------------------------
module tb_bracket_balance_checker;
	timeunit 1ns;
	timeprecision 1ps;

	localparam time         CLK_PERIOD   = 8ns;
	localparam int          RESET_CYCLES = 10;
	localparam int          LIMIT_CYCLES = 600000;
	localparam int          DRAIN_CYCLES = 16;
	localparam int          HOLD_CYCLES  = 300;
	localparam int          RANDOM_ITEMS = 460;
	localparam int          QUIET_ITEMS  = 100;
	localparam logic [1:0]  CMD_UNUSED   = 2'd3;
	localparam logic [15:0] LINE_MAX     = 16'hFFFF;

	typedef struct packed {
		bbc_pkg::status_t st;
		logic [15:0]      ln;
		logic [7:0]       ch;
	} report_t;

	typedef enum {
		TXT_BALANCED,
		TXT_UNCLOSED,
		TXT_MISMATCH,
		TXT_OVERFLOW,
		TXT_NOISE
	} text_kind_t;

	// bracket nesting predictor and queue of pending reports
	class bracket_scoreboard;
		bbc_pkg::kind_t   nest[bbc_pkg::STACK_DEPTH];
		int unsigned      depth = 0;
		int unsigned      lines = 0;
		bbc_pkg::status_t err_st = bbc_pkg::ST_BALANCED;
		logic [15:0]      err_ln = '0;
		bbc_pkg::kind_t   err_kind = bbc_pkg::KIND_ROUND;
		report_t          expected_reports[$];
		int unsigned      errors = 0;

		static function logic [7:0] bracket_code(bbc_pkg::kind_t k, bit closing);
			case (k)
				bbc_pkg::KIND_ROUND:
					return closing ? bbc_pkg::CH_RROUND : bbc_pkg::CH_LROUND;
				bbc_pkg::KIND_SQUARE:
					return closing ? bbc_pkg::CH_RSQUARE : bbc_pkg::CH_LSQUARE;
				bbc_pkg::KIND_CURLY:
					return closing ? bbc_pkg::CH_RCURLY : bbc_pkg::CH_LCURLY;
				default:
					return bbc_pkg::CH_NONE;
			endcase
		endfunction

		function int pending();
			return expected_reports.size();
		endfunction

		// advance the predicted state by one accepted request
		function void note_request(logic [1:0] cmd, logic [7:0] code);
			bbc_pkg::kind_t   k;
			bit               is_open;
			bit               is_br;
			bbc_pkg::status_t fault;
			report_t          r;
			case (cmd)
				bbc_pkg::CMD_CHAR: begin
					is_br   = 1'b1;
					is_open = 1'b1;
					k       = bbc_pkg::KIND_ROUND;
					fault   = bbc_pkg::ST_BALANCED;
					case (code)
						bbc_pkg::CH_LROUND:  k = bbc_pkg::KIND_ROUND;
						bbc_pkg::CH_LSQUARE: k = bbc_pkg::KIND_SQUARE;
						bbc_pkg::CH_LCURLY:  k = bbc_pkg::KIND_CURLY;
						bbc_pkg::CH_RROUND: begin
							k = bbc_pkg::KIND_ROUND;
							is_open = 1'b0;
						end
						bbc_pkg::CH_RSQUARE: begin
							k = bbc_pkg::KIND_SQUARE;
							is_open = 1'b0;
						end
						bbc_pkg::CH_RCURLY: begin
							k = bbc_pkg::KIND_CURLY;
							is_open = 1'b0;
						end
						default: is_br = 1'b0;
					endcase
					// characters are dropped once an error is latched
					if (is_br && err_st == bbc_pkg::ST_BALANCED) begin
						if (is_open) begin
							if (depth >= bbc_pkg::STACK_DEPTH) begin
								fault = bbc_pkg::ST_OVERFLOW;
							end else begin
								nest[depth] = k;
								depth++;
							end
						end else if (depth != 0 && nest[depth-1] == k) begin
							depth--;
						end else begin
							// closer on an empty stack counts as a mismatch too
							fault = bbc_pkg::ST_MISMATCH;
						end
						if (fault != bbc_pkg::ST_BALANCED) begin
							err_st   = fault;
							err_kind = k;
							err_ln   = (lines >= LINE_MAX) ? LINE_MAX : 16'(lines + 1);
						end
					end
				end
				bbc_pkg::CMD_EOL: begin
					if (lines < LINE_MAX)
						lines++;
				end
				bbc_pkg::CMD_EOT: begin
					if (err_st == bbc_pkg::ST_MISMATCH)
						r = '{bbc_pkg::ST_MISMATCH, err_ln, bracket_code(err_kind, 1'b0)};
					else if (err_st == bbc_pkg::ST_OVERFLOW)
						r = '{bbc_pkg::ST_OVERFLOW, err_ln, bbc_pkg::CH_NONE};
					else if (depth != 0)
						r = '{bbc_pkg::ST_UNCLOSED, 16'(lines),
							bracket_code(nest[depth-1], 1'b1)};
					else
						r = '{bbc_pkg::ST_BALANCED, 16'd0, bbc_pkg::CH_NONE};
					expected_reports = {expected_reports, r};
					// end of text returns to the reset state
					depth    = 0;
					lines    = 0;
					err_st   = bbc_pkg::ST_BALANCED;
					err_ln   = '0;
					err_kind = bbc_pkg::KIND_ROUND;
				end
				default: ;
			endcase
		endfunction

		// compare one accepted report with the oldest prediction
		function void check_report(logic [1:0] st, logic [15:0] ln, logic [7:0] ch);
			report_t r;
			if (expected_reports.size() == 0) begin
				$display("%0t: unexpected report status=%0d line=%0d char=%h",
					$time, st, ln, ch);
				errors++;
				return;
			end
			r = expected_reports.pop_front();
			if (st !== r.st) begin
				$display("%0t: status expected %0d actual %0d", $time, r.st, st);
				errors++;
			end
			if (ln !== r.ln) begin
				$display("%0t: fault_line expected %0d actual %0d", $time, r.ln, ln);
				errors++;
			end
			if (ch !== r.ch) begin
				$display("%0t: bracket_char expected %h actual %h", $time, r.ch, ch);
				errors++;
			end
		endfunction
	endclass

	logic                        clk = 1'b0;
	logic                        arst_n = 1'b0;
	logic                        char_valid = 1'b0;
	logic                        char_stall;
	logic [1:0]                  command = bbc_pkg::CMD_CHAR;
	logic [7:0]                  char_code = '0;
	logic                        report_valid;
	logic                        report_stall = 1'b0;
	logic [1:0]                  status;
	logic [bbc_pkg::LINE_W-1:0]  fault_line;
	logic [7:0]                  bracket_char;

	bracket_scoreboard sb;
	bit                quiet = 1'b0;
	bit                hold_req = 1'b0;
	int                requests_sent = 0;
	int                cycle_count = 0;

	bracket_balance_checker u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.char_valid   (char_valid),
		.char_stall   (char_stall),
		.command      (command),
		.char_code    (char_code),
		.report_valid (report_valid),
		.report_stall (report_stall),
		.status       (status),
		.fault_line   (fault_line),
		.bracket_char (bracket_char)
	);

	always #(CLK_PERIOD/2) clk = ~clk;

	// end the run if it hangs
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= LIMIT_CYCLES) begin
			$display("bracket_balance_checker: mismatch");
			$finish;
		end
	end

	// check every accepted report
	always @(posedge clk) begin
		if (report_valid && !report_stall)
			sb.check_report(status, fault_line, bracket_char);
	end

	// report side: random stall bursts plus one long hold-off on request
	initial begin
		int burst_left;
		int hold_left;
		burst_left = 0;
		hold_left  = 0;
		forever begin
			@(negedge clk);
			if (hold_left > 0) begin
				hold_left--;
			end else if (hold_req) begin
				hold_left = HOLD_CYCLES;
				hold_req  = 1'b0;
			end
			if (burst_left > 0)
				burst_left--;
			else if (!quiet && $urandom_range(0, 7) == 0)
				burst_left = $urandom_range(1, 12);
			report_stall <= (hold_left > 0) || (burst_left > 0);
		end
	end

	function automatic bbc_pkg::kind_t rand_kind();
		return bbc_pkg::kind_t'($urandom_range(0, 2));
	endfunction

	// any byte that is not a bracket
	function automatic logic [7:0] filler_char();
		logic [7:0] c;
		c = 8'($urandom_range(0, 255));
		case (c)
			bbc_pkg::CH_LROUND, bbc_pkg::CH_RROUND, bbc_pkg::CH_LSQUARE,
			bbc_pkg::CH_RSQUARE, bbc_pkg::CH_LCURLY, bbc_pkg::CH_RCURLY:
				c = 8'h20;
			default: ;
		endcase
		return c;
	endfunction

	// offer one request, with an optional gap first, and hold it until taken
	task automatic send_request(input logic [1:0] cmd, input logic [7:0] code);
		int gap;
		gap = (!quiet && $urandom_range(0, 5) == 0) ? $urandom_range(1, 12) : 0;
		@(negedge clk);
		if (gap > 0) begin
			char_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		char_valid <= 1'b1;
		command    <= cmd;
		char_code  <= code;
		do @(posedge clk); while (char_stall);
		sb.note_request(cmd, code);
		requests_sent++;
	endtask

	task automatic send_bracket(input bbc_pkg::kind_t k, input bit closing);
		send_request(bbc_pkg::CMD_CHAR, bracket_scoreboard::bracket_code(k, closing));
	endtask

	task automatic send_eot();
		send_request(bbc_pkg::CMD_EOT, 8'($urandom_range(0, 255)));
	endtask

	// drop valid, then wait for every predicted report
	task automatic wait_reports_done();
		@(negedge clk);
		char_valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
	endtask

	// one text: a random body, well-nested unless noise, then an ending by mode
	task automatic send_text(input text_kind_t mode);
		bbc_pkg::kind_t open_kinds[$];
		bbc_pkg::kind_t k;
		int             n;
		n = $urandom_range(2, 24);
		repeat (n) begin
			if (mode == TXT_NOISE) begin
				send_request(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
			end else begin
				case ($urandom_range(0, 9))
					0, 1, 2: begin
						if (open_kinds.size() < 40) begin
							k = rand_kind();
							open_kinds = {open_kinds, k};
							send_bracket(k, 1'b0);
						end
					end
					3, 4, 5: begin
						if (open_kinds.size() > 0) begin
							k = open_kinds.pop_back();
							send_bracket(k, 1'b1);
						end
					end
					6, 7: send_request(bbc_pkg::CMD_CHAR, filler_char());
					default: send_request(bbc_pkg::CMD_EOL, 8'($urandom_range(0, 255)));
				endcase
			end
		end
		case (mode)
			TXT_BALANCED: begin
				while (open_kinds.size() > 0) begin
					k = open_kinds.pop_back();
					send_bracket(k, 1'b1);
					if ($urandom_range(0, 3) == 0)
						send_request(bbc_pkg::CMD_EOL, 8'($urandom_range(0, 255)));
				end
			end
			TXT_UNCLOSED: begin
				if (open_kinds.size() == 0)
					send_bracket(rand_kind(), 1'b0);
			end
			TXT_MISMATCH: begin
				if (open_kinds.size() == 0)
					k = rand_kind();
				else
					k = bbc_pkg::kind_t'((int'(open_kinds[$]) + $urandom_range(1, 2)) % 3);
				send_bracket(k, 1'b1);
				// brackets after the fault must be dropped
				repeat ($urandom_range(0, 5))
					send_bracket(rand_kind(), 1'($urandom_range(0, 1)));
			end
			TXT_OVERFLOW: begin
				repeat (bbc_pkg::STACK_DEPTH - open_kinds.size() + $urandom_range(1, 3))
					send_bracket(rand_kind(), 1'b0);
				repeat ($urandom_range(0, 2))
					send_bracket(rand_kind(), 1'b1);
			end
			default: ;
		endcase
		if ($urandom_range(0, 1) == 0)
			send_request(bbc_pkg::CMD_EOL, 8'($urandom_range(0, 255)));
		send_eot();
	endtask

	// main sequence
	initial begin
		int         mark;
		text_kind_t mode;
		sb = new();
		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// empty text
		send_eot();
		// closer with nothing open
		send_request(bbc_pkg::CMD_CHAR, bbc_pkg::CH_RROUND);
		send_eot();
		// three openers left open
		send_request(bbc_pkg::CMD_CHAR, bbc_pkg::CH_LROUND);
		send_request(bbc_pkg::CMD_CHAR, bbc_pkg::CH_LSQUARE);
		send_request(bbc_pkg::CMD_CHAR, bbc_pkg::CH_LCURLY);
		send_request(bbc_pkg::CMD_EOL, 8'hFF);
		send_eot();
		// wrong closer, then every bracket after it dropped
		send_request(bbc_pkg::CMD_CHAR, bbc_pkg::CH_LCURLY);
		send_request(bbc_pkg::CMD_CHAR, bbc_pkg::CH_RSQUARE);
		send_request(bbc_pkg::CMD_CHAR, bbc_pkg::CH_LROUND);
		send_request(bbc_pkg::CMD_EOL, 8'h00);
		send_request(bbc_pkg::CMD_CHAR, bbc_pkg::CH_RCURLY);
		send_eot();
		// plain bytes and the unused command are ignored
		send_request(bbc_pkg::CMD_CHAR, bbc_pkg::CH_LSQUARE);
		send_request(bbc_pkg::CMD_CHAR, bbc_pkg::CH_RSQUARE);
		send_request(bbc_pkg::CMD_CHAR, 8'h00);
		send_request(bbc_pkg::CMD_CHAR, 8'hFF);
		send_request(CMD_UNUSED, bbc_pkg::CH_LROUND);
		send_request(bbc_pkg::CMD_EOL, 8'h55);
		send_eot();

		// sender pauses until every report is out
		wait_reports_done();

		// long report hold-off while requests keep coming
		hold_req = 1'b1;
		repeat (12) begin
			send_request(bbc_pkg::CMD_CHAR, bbc_pkg::CH_LCURLY);
			send_eot();
		end
		wait_reports_done();

		// at least one push on a full stack
		send_text(TXT_OVERFLOW);

		// random texts, the last stretch without idling
		mark = requests_sent;
		while (requests_sent < mark + RANDOM_ITEMS) begin
			if (requests_sent >= mark + RANDOM_ITEMS - QUIET_ITEMS)
				quiet = 1'b1;
			case ($urandom_range(0, 19))
				0, 1, 2, 3, 4, 5, 6: mode = TXT_BALANCED;
				7, 8, 9, 10:         mode = TXT_UNCLOSED;
				11, 12, 13, 14, 15:  mode = TXT_MISMATCH;
				16:                  mode = TXT_OVERFLOW;
				default:             mode = TXT_NOISE;
			endcase
			send_text(mode);
		end

		wait_reports_done();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.errors == 0)
			$display("bracket_balance_checker: match");
		else
			$display("bracket_balance_checker: mismatch");
		$finish;
	end

endmodule

### filelist.f
sv/bbc_pkg.sv
sv/bbc_ram.sv
sv/bbc_front.sv
sv/bbc_queue.sv
sv/bbc_back.sv
sv/bracket_balance_checker.sv
sim/tb_bracket_balance_checker.sv
